// ===== sv/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation codes, widths, shared types.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned OpWidth   = 3;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CMP  = 3'd4,
    OP_INC  = 3'd5,
    OP_DEC  = 3'd6,
    OP_SIMP = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } cmp_e;
endpackage

// ===== sv/rau_mul.sv =====
// Bit-serial shift-add multiplier, product modulo 2^Width, one multiplier bit per cycle.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_mul import rau_pkg::*; #(
  parameter int unsigned Width = DataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [Width-1:0] p_o
);
  localparam int unsigned CntW = $clog2(Width + 1);
  logic [Width-1:0] mc_q, mc_d, mp_q, mp_d, acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    mc_d = mc_q; mp_d = mp_q; acc_d = acc_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      mc_d = a_i; mp_d = b_i; acc_d = '0; cnt_d = CntW'(Width); busy_d = 1'b1;
    end else if (busy_q) begin
      if (mp_q[0]) acc_d = acc_q + mc_q;
      mc_d = mc_q << 1;
      mp_d = mp_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q <= mc_d; mp_q <= mp_d; acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ===== sv/rau_div.sv =====
// Restoring divider, one quotient bit per cycle; also yields the remainder.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_div import rau_pkg::*; #(
  parameter int unsigned Width = DataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] n_i,
  input  logic [Width-1:0] d_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [Width-1:0] q_o,
  output logic [Width-1:0] r_o
);
  localparam int unsigned CntW = $clog2(Width + 1);
  logic [Width-1:0] q_q, q_d, d_q, d_d;
  logic [Width:0]   r_q, r_d, trial;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    q_d = q_q; d_d = d_q; r_d = r_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {r_q[Width-1:0], q_q[Width-1]} - {1'b0, d_q};
    if (start_i) begin
      q_d = n_i; d_d = d_i; r_d = '0; cnt_d = CntW'(Width); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[Width]) begin
        r_d = trial;
        q_d = {q_q[Width-2:0], 1'b1};
      end else begin
        r_d = {r_q[Width-1:0], q_q[Width-1]};
        q_d = {q_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; d_q <= d_d; r_q <= r_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign q_o    = q_q;
  assign r_o    = r_q[Width-1:0];
endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer over a serial multiplier
// and a serial divider. Depends on rau_pkg, rau_mul, rau_div.
//
// Usage: drive operation_i and the four fraction fields with start high while
// busy is low; the item is taken at that edge. Exactly one result follows,
// shown for one cycle with valid_o high; the receiver cannot stall it.
// Work per item on the bit-serial shift-add multiplier and restoring divider,
// in order from acceptance to the result:
//   increment, decrement: the sum or difference, then the result
//   multiply, divide, compare: 2 products, a closing step, then the result
//   add, subtract: 3 products, the sum or difference, then the result
//   simplify: a load step, gcd by Euclid with one division per remainder step
//   (up to about 92 steps), a step to close the gcd, two divisions (skipped
//   when the gcd is zero) and the result.
// One item at a time; busy is high from acceptance through the result cycle.
// Reset clears the sequencer to idle; no result is pending after reset.
`timescale 1ns / 1ps
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned Width = DataWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [OpWidth-1:0] operation_i,
  input  logic signed [Width-1:0] a_numerator_i,
  input  logic [Width-1:0]   a_denominator_i,
  input  logic signed [Width-1:0] b_numerator_i,
  input  logic [Width-1:0]   b_denominator_i,
  output logic               valid_o,
  output logic signed [Width-1:0] result_numerator_o,
  output logic [Width-1:0]   result_denominator_o,
  output logic [1:0]         compare_code_o
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL1  = 9'b000000010,
    S_MUL2  = 9'b000000100,
    S_MUL3  = 9'b000001000,
    S_GCD   = 9'b000010000,
    S_DIVN  = 9'b000100000,
    S_DIVD  = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [OpWidth-1:0] op_q, op_d;
  logic [Width-1:0]  an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [Width-1:0]  p1_q, p1_d, p2_q, p2_d, rn_q, rn_d, rd_q, rd_d;
  logic [Width-1:0]  gx_q, gx_d, gy_q, gy_d;
  logic [1:0]        cc_q, cc_d;
  logic              go_q, go_d;

  logic              mul_start, mul_busy, mul_done;
  logic              div_start, div_busy, div_done;
  logic [Width-1:0]  mul_a, mul_b, mul_p, div_n, div_d, div_q, div_r;
  logic [Width-1:0]  mag_an, mag_bn, neg_q;
  logic [Width-1:0]  pb, qb;

  assign mag_an = an_q[Width-1] ? (~an_q + 1'b1) : an_q;
  assign mag_bn = bn_q[Width-1] ? (~bn_q + 1'b1) : bn_q;
  assign neg_q  = ~div_q + 1'b1;
  assign pb = p1_q ^ {1'b1, {(Width-1){1'b0}}};
  assign qb = p2_q ^ {1'b1, {(Width-1){1'b0}}};

  rau_mul #(.Width(Width)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .done_o(mul_done), .p_o(mul_p)
  );

  rau_div #(.Width(Width)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n), .d_i(div_d),
    .busy_o(div_busy), .done_o(div_done), .q_o(div_q), .r_o(div_r)
  );

  always_comb begin
    state_d = state_q; op_d = op_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    p1_d = p1_q; p2_d = p2_q; rn_d = rn_q; rd_d = rd_q;
    gx_d = gx_q; gy_d = gy_q; cc_d = cc_q; go_d = 1'b0;
    mul_start = 1'b0; mul_a = an_q; mul_b = bd_q;
    div_start = 1'b0; div_n = gx_q; div_d = gy_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = operation_i;
          an_d = a_numerator_i; ad_d = a_denominator_i;
          bn_d = b_numerator_i; bd_d = b_denominator_i;
          cc_d = CMP_LT; go_d = 1'b1;
          case (op_e'(operation_i))
            OP_INC, OP_DEC: state_d = S_FIN;
            OP_SIMP:        state_d = S_GCD;
            default:        state_d = S_MUL1;
          endcase
        end
      end
      // products: a_n*b_d (a_n*b_n for mul), then b_n*a_d, a_d*|b_n| or a_d*b_d
      S_MUL1: begin
        mul_start = go_q;
        if (op_e'(op_q) == OP_MUL) mul_b = bn_q;
        if (mul_done) begin
          p1_d = mul_p; go_d = 1'b1; state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        mul_start = go_q;
        case (op_e'(op_q))
          OP_ADD, OP_SUB, OP_CMP: begin mul_a = bn_q; mul_b = ad_q; end
          OP_DIV:  begin mul_a = ad_q; mul_b = mag_bn; end
          default: begin mul_a = ad_q; mul_b = bd_q; end
        endcase
        if (mul_done) begin
          p2_d = mul_p; go_d = 1'b1;
          state_d = (op_e'(op_q) == OP_ADD || op_e'(op_q) == OP_SUB) ? S_MUL3 : S_FIN;
        end
      end
      S_MUL3: begin
        mul_start = go_q;
        mul_a = ad_q; mul_b = bd_q;
        if (mul_done) begin
          rd_d = mul_p; state_d = S_FIN;
        end
      end
      // Euclid: gx holds x, gy holds y; each step one division for x % y
      S_GCD: begin
        if (go_q) begin
          gx_d = mag_an; gy_d = ad_q;
        end else if (!div_busy && !div_done && gy_q != '0) begin
          div_start = 1'b1;
        end else if (div_done) begin
          gx_d = gy_q; gy_d = div_r;
        end else if (!div_busy && gy_q == '0) begin
          if (gx_q == '0) begin
            rn_d = an_q; rd_d = ad_q; state_d = S_OUT;
          end else begin
            gy_d = gx_q; go_d = 1'b1; state_d = S_DIVN;
          end
        end
      end
      S_DIVN: begin
        div_start = go_q; div_n = mag_an; div_d = gy_q;
        if (div_done) begin
          rn_d = an_q[Width-1] ? neg_q : div_q; go_d = 1'b1; state_d = S_DIVD;
        end
      end
      S_DIVD: begin
        div_start = go_q; div_n = ad_q; div_d = gy_q;
        if (div_done) begin
          rd_d = div_q; state_d = S_OUT;
        end
      end
      S_FIN: begin
        state_d = S_OUT;
        case (op_e'(op_q))
          OP_ADD: rn_d = p1_q + p2_q;
          OP_SUB: rn_d = p1_q - p2_q;
          OP_MUL: begin rn_d = p1_q; rd_d = p2_q; end
          OP_DIV: begin rn_d = bn_q[Width-1] ? (~p1_q + 1'b1) : p1_q; rd_d = p2_q; end
          OP_CMP: begin
            rn_d = an_q; rd_d = ad_q;
            cc_d = (pb < qb) ? CMP_LT : ((pb == qb) ? CMP_EQ : CMP_GT);
          end
          OP_INC: begin rn_d = an_q + ad_q; rd_d = ad_q; end
          OP_DEC: begin rn_d = an_q - ad_q; rd_d = ad_q; end
          default: begin rn_d = an_q; rd_d = ad_q; end
        endcase
      end
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; go_q <= 1'b0;
    end else begin
      state_q <= state_d; go_q <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    p1_q <= p1_d; p2_q <= p2_d; rn_q <= rn_d; rd_q <= rd_d;
    gx_q <= gx_d; gy_q <= gy_d; cc_q <= cc_d;
  end

  assign busy                 = (state_q != S_IDLE);
  assign valid_o              = (state_q == S_OUT);
  assign result_numerator_o   = rn_q;
  assign result_denominator_o = rd_q;
  assign compare_code_o       = cc_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o && !busy)
    else $error("result strobe longer than one cycle");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !valid_o)
    else $error("accepted item did not start work");
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy && div_busy))
    else $error("multiplier and divider active together");
  a_cc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && op_e'(op_q) != OP_CMP) |-> compare_code_o == CMP_LT)
    else $error("compare code set outside compare");
endmodule

// ===== test/rau_checker.sv =====
// Result checker for the rational arithmetic unit: predicts each accepted item
// and compares the strobed result against the oldest prediction. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_checker import rau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [OpWidth-1:0]   operation_i,
  input  logic [DataWidth-1:0] a_numerator_i,
  input  logic [DataWidth-1:0] a_denominator_i,
  input  logic [DataWidth-1:0] b_numerator_i,
  input  logic [DataWidth-1:0] b_denominator_i,
  input  logic                 valid_i,
  input  logic [DataWidth-1:0] result_numerator_i,
  input  logic [DataWidth-1:0] result_denominator_i,
  input  logic [1:0]           compare_code_i,
  output int                   pending_o,
  output int                   fail_count_o
);
  typedef logic [DataWidth-1:0] word_t;
  typedef struct packed {
    word_t      num;
    word_t      den;
    logic [1:0] code;
  } fraction_t;

  fraction_t expected_q[$];
  localparam word_t SignBit = {1'b1, {(DataWidth-1){1'b0}}};

  function automatic word_t magnitude(word_t x);
    return x[DataWidth-1] ? -x : x;
  endfunction

  function automatic word_t gcd_of(word_t x, word_t y);
    word_t r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic fraction_t rational_result(op_e op, word_t an, word_t ad,
                                                word_t bn, word_t bd);
    fraction_t f;
    word_t p, q, m, g;
    f = '0;
    case (op)
      OP_ADD: begin
        f.num = an * bd + bn * ad;
        f.den = ad * bd;
      end
      OP_SUB: begin
        f.num = an * bd - bn * ad;
        f.den = ad * bd;
      end
      OP_MUL: begin
        f.num = an * bn;
        f.den = ad * bd;
      end
      OP_DIV: begin
        f.num = bn[DataWidth-1] ? -(an * bd) : an * bd;
        f.den = ad * magnitude(bn);
      end
      OP_CMP: begin
        p = (an * bd) ^ SignBit;
        q = (bn * ad) ^ SignBit;
        f.code = (p < q) ? CMP_LT : ((p == q) ? CMP_EQ : CMP_GT);
        f.num = an;
        f.den = ad;
      end
      OP_INC: begin
        f.num = an + ad;
        f.den = ad;
      end
      OP_DEC: begin
        f.num = an - ad;
        f.den = ad;
      end
      default: begin
        m = magnitude(an);
        g = gcd_of(m, ad);
        if (g == 0) begin
          f.num = an;
          f.den = ad;
        end else begin
          f.num = an[DataWidth-1] ? -(m / g) : m / g;
          f.den = ad / g;
        end
      end
    endcase
    return f;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    fraction_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        expected_q.push_back(rational_result(op_e'(operation_i), a_numerator_i,
                                             a_denominator_i, b_numerator_i,
                                             b_denominator_i));
      end
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result num=%h den=%h", result_numerator_i,
                 result_denominator_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (result_numerator_i !== want.num || result_denominator_i !== want.den ||
              compare_code_i !== want.code) begin
            if (result_numerator_i !== want.num)
              $error("result_numerator expected %h actual %h", want.num,
                     result_numerator_i);
            if (result_denominator_i !== want.den)
              $error("result_denominator expected %h actual %h", want.den,
                     result_denominator_i);
            if (compare_code_i !== want.code)
              $error("compare_code expected %0d actual %0d", want.code,
                     compare_code_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end
endmodule

// ===== test/tb_rational_arithmetic_unit.sv =====
// Testbench top for the rational arithmetic unit: drives directed and random
// items, gives the verdict. Depends on rau_pkg, rau_checker, rational_arithmetic_unit.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
  import rau_pkg::*;
  typedef logic [DataWidth-1:0] word_t;

  localparam longint unsigned CycleLimit = 60000000;
  localparam word_t MinNeg = {1'b1, {(DataWidth-1){1'b0}}};
  localparam word_t MaxPos = {1'b0, {(DataWidth-1){1'b1}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OpWidth-1:0] operation = '0;
  word_t a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic valid;
  word_t res_num, res_den;
  logic [1:0] cmp_code;
  int pending, fail_count;
  int idle_pct = 0;
  longint unsigned cycles = 0;

  always #4 clk_i = ~clk_i;

  rational_arithmetic_unit dut (
    .clk_i, .rst_ni, .start, .busy,
    .operation_i(operation),
    .a_numerator_i(a_num), .a_denominator_i(a_den),
    .b_numerator_i(b_num), .b_denominator_i(b_den),
    .valid_o(valid),
    .result_numerator_o(res_num), .result_denominator_o(res_den),
    .compare_code_o(cmp_code)
  );

  rau_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .operation_i(operation),
    .a_numerator_i(a_num), .a_denominator_i(a_den),
    .b_numerator_i(b_num), .b_denominator_i(b_den),
    .valid_i(valid), .result_numerator_i(res_num),
    .result_denominator_i(res_den), .compare_code_i(cmp_code),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("rational_arithmetic_unit regression: fail");
      $finish;
    end
  end

  function automatic word_t rand_word(int kind);
    case (kind)
      0: return {$urandom, $urandom};
      1: return word_t'($urandom_range(0, 40));
      2: return -word_t'($urandom_range(1, 40));
      3: return word_t'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 4))
          0: return MinNeg;
          1: return MaxPos;
          2: return '1;
          3: return '0;
          default: return word_t'(1);
        endcase
      end
    endcase
  endfunction

  task automatic send_item(op_e op, word_t an, word_t ad, word_t bn, word_t bd);
    start <= 1'b1;
    operation <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    op_e op;
    int kind;
    word_t an;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_item(OP_ADD, MaxPos, '1, MinNeg, '1);
    send_item(OP_SUB, MinNeg, 64'd3, MaxPos, 64'd5);
    send_item(OP_MUL, '1, '1, MinNeg, MaxPos);
    send_item(OP_DIV, 64'd7, 64'd3, MinNeg, 64'd2);
    send_item(OP_DIV, -64'd7, 64'd3, -64'd5, 64'd9);
    send_item(OP_DIV, 64'd1, 64'd1, '0, 64'd1);
    send_item(OP_CMP, 64'd1, 64'd2, 64'd2, 64'd4);
    send_item(OP_CMP, -64'd1, 64'd2, 64'd1, 64'd4);
    send_item(OP_CMP, MaxPos, '1, MinNeg, '1);
    send_item(OP_INC, MaxPos, 64'd1, '0, '0);
    send_item(OP_DEC, MinNeg, 64'd1, '1, '1);
    send_item(OP_INC, '0, '0, '1, '1);
    send_item(OP_SIMP, '0, '0, '1, '1);
    send_item(OP_SIMP, '0, 64'd12, '0, '0);
    send_item(OP_SIMP, -64'd12, '0, '0, '0);
    send_item(OP_SIMP, 64'd12, '0, '0, '0);
    send_item(OP_SIMP, MinNeg, 64'd1024, '0, '0);
    send_item(OP_SIMP, -64'd84, 64'd36, '0, '0);
    send_item(OP_SIMP, MaxPos, '1, '0, '0);
    send_item(OP_SIMP, MinNeg, MinNeg, '0, '0);
    drain();

    for (int i = 0; i < 1530; i++) begin
      case (i / 380)
        0: idle_pct = 0;
        1: idle_pct = 63;
        2: idle_pct = 0;
        default: idle_pct = 6;
      endcase
      if (i == 700) drain();
      op = op_e'($urandom_range(0, 7));
      // draw most reduction numerators from the short or special kinds to bound gcd time
      if (op == OP_SIMP && $urandom_range(0, 3) != 0) kind = $urandom_range(1, 4);
      else kind = $urandom_range(0, 4);
      an = rand_word(kind);
      send_item(op, an, rand_word(kind == 0 ? 0 : $urandom_range(0, 4)),
                rand_word($urandom_range(0, 4)), rand_word($urandom_range(0, 4)));
    end
    drain();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("rational_arithmetic_unit regression: pass");
    end else begin
      $display("rational_arithmetic_unit regression: fail");
    end
    $finish;
  end
endmodule

// ===== rational_arithmetic_unit.f =====
sv/rau_pkg.sv
sv/rau_mul.sv
sv/rau_div.sv
sv/rational_arithmetic_unit.sv
test/rau_checker.sv
test/tb_rational_arithmetic_unit.sv
